FILE: design/cxyft_pkg.sv
package cxyft_pkg;

    // position format, documents the Q format only
    localparam int POS_FRAC_BITS = 16;
    localparam int LEN_EXTRA_SHIFT = 16;

    // register map
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_X_FACTOR_ADDR = 3'd0;
    localparam logic [1:0] X_FACTOR_RESET = 2'd1;

    // square root unit: radicand, root and remainder widths
    localparam int SQ_RAD_W = 86;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_REM_W = SQ_ROOT_W + 1;
    localparam int SQ_STAGES = SQ_ROOT_W;

    // feed scaling: product, divisor and quotient widths
    localparam int DV_D_W = 41;
    localparam int DV_Q_W = 35;
    localparam int DV_N_W = 75;
    localparam int DV_STAGES = DV_Q_W;

    // stage counts of each section
    localparam int FRONT_LAT = 3;
    localparam int SQRT_LAT = SQ_STAGES;
    localparam int DIV_LAT = 2 + DV_STAGES;
    localparam int CORE_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic [31:0]        feed_in;
        logic               rapid;
    } in_t;

    typedef struct packed {
        logic signed [31:0] motor_a;
        logic signed [31:0] motor_b;
        logic signed [31:0] motor_z;
        logic [31:0]        feed_out;
        logic               zero_length;
    } out_t;

    // fields that ride alongside the length and feed math
    typedef struct packed {
        logic signed [31:0] motor_a;
        logic signed [31:0] motor_b;
        logic signed [31:0] motor_z;
        logic [31:0]        feed_in;
        logic               bypass;
        logic               zero_length;
    } side_t;

endpackage

FILE: design/cxyft_front.sv
module cxyft_front (
    input  logic                            aclk,
    input  logic                            en,
    input  logic                            k_two,
    input  cxyft_pkg::in_t                  in_data,
    output logic [cxyft_pkg::SQ_RAD_W-1:0]  cart_rad,
    output logic [cxyft_pkg::SQ_RAD_W-1:0]  mot_rad
);

    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic signed [34:0] da_reg, db_reg;
    logic [65:0] sqx_reg, sqy_reg, sqz_reg;
    logic [67:0] sqa_reg, sqb_reg;
    logic [65:0] cart_reg;
    logic [68:0] mot_reg;

    logic signed [32:0] dx_next, dy_next, dz_next;
    logic signed [34:0] kdx, dy_ext;
    logic [32:0] mx, my, mz;
    logic [33:0] ma, mb;
    logic signed [34:0] na, nb;
    logic signed [32:0] nx, ny, nz;

    always_comb begin
        dx_next = {in_data.target_x[31], in_data.target_x} - {in_data.start_x[31], in_data.start_x};
        dy_next = {in_data.target_y[31], in_data.target_y} - {in_data.start_y[31], in_data.start_y};
        dz_next = {in_data.target_z[31], in_data.target_z} - {in_data.start_z[31], in_data.start_z};
        kdx = k_two ? {dx_next[32], dx_next, 1'b0} : {{2{dx_next[32]}}, dx_next};
        dy_ext = {{2{dy_next[32]}}, dy_next};
        nx = -dx_reg;
        ny = -dy_reg;
        nz = -dz_reg;
        na = -da_reg;
        nb = -db_reg;
        mx = dx_reg[32] ? nx : dx_reg;
        my = dy_reg[32] ? ny : dy_reg;
        mz = dz_reg[32] ? nz : dz_reg;
        ma = da_reg[34] ? na[33:0] : da_reg[33:0];
        mb = db_reg[34] ? nb[33:0] : db_reg[33:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // deltas in Cartesian and motor space
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            dz_reg <= dz_next;
            da_reg <= kdx + dy_ext;
            db_reg <= kdx - dy_ext;
            // squares
            sqx_reg <= mx * mx;
            sqy_reg <= my * my;
            sqz_reg <= mz * mz;
            sqa_reg <= ma * ma;
            sqb_reg <= mb * mb;
            // sums
            cart_reg <= sqx_reg + sqy_reg + sqz_reg;
            mot_reg <= {1'b0, sqa_reg} + {1'b0, sqb_reg} + {3'b000, sqz_reg};
        end
    end

    assign cart_rad = {4'b0000, cart_reg, {cxyft_pkg::LEN_EXTRA_SHIFT{1'b0}}};
    assign mot_rad = {1'b0, mot_reg, {cxyft_pkg::LEN_EXTRA_SHIFT{1'b0}}};

endmodule

FILE: design/cxyft_sqrt.sv
module cxyft_sqrt (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [cxyft_pkg::SQ_RAD_W-1:0]   rad,
    output logic [cxyft_pkg::SQ_ROOT_W-1:0]  root
);

    localparam int N = cxyft_pkg::SQ_STAGES;
    localparam int RW = cxyft_pkg::SQ_RAD_W;
    localparam int QW = cxyft_pkg::SQ_ROOT_W;
    localparam int MW = cxyft_pkg::SQ_REM_W;

    logic [MW-1:0] rem_reg [N];
    logic [QW-1:0] root_reg [N];
    logic [RW-1:0] rad_reg [N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic [MW-1:0] rem_in;
            logic [QW-1:0] root_in;
            logic [RW-1:0] rad_in;
            logic [MW+1:0] cur, trial, diff;
            logic fit;

            if (g == 0) begin : g_first
                assign rem_in = '0;
                assign root_in = '0;
                assign rad_in = rad;
            end else begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign rad_in = rad_reg[g-1];
            end

            // two radicand bits a stage, one root bit
            always_comb begin
                cur = {rem_in, rad_in[RW-1:RW-2]};
                trial = {1'b0, root_in, 2'b01};
                fit = cur >= trial;
                diff = cur - trial;
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g] <= fit ? diff[MW-1:0] : cur[MW-1:0];
                    root_reg[g] <= {root_in[QW-2:0], fit};
                end
            end

            if (g < N - 1) begin : g_pass
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rad_reg[g] <= {rad_in[RW-3:0], 2'b00};
                    end
                end
            end
        end
    endgenerate

    assign root = root_reg[N-1];

endmodule

FILE: design/cxyft_div.sv
module cxyft_div (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [31:0]                      feed,
    input  logic [cxyft_pkg::SQ_ROOT_W-1:0]  len_mot,
    input  logic [cxyft_pkg::SQ_ROOT_W-1:0]  len_cart,
    output logic [cxyft_pkg::DV_Q_W-1:0]     quot
);

    localparam int N = cxyft_pkg::DV_STAGES;
    localparam int DW = cxyft_pkg::DV_D_W;
    localparam int QW = cxyft_pkg::DV_Q_W;
    localparam int NW = cxyft_pkg::DV_N_W;
    localparam int HW = cxyft_pkg::SQ_ROOT_W - 32;

    logic [63:0]        plo_reg;
    logic [31+HW:0]     phi_reg;
    logic [DW-1:0]      da_reg, db_reg;
    logic [NW-1:0]      num_reg;
    logic [DW-1:0]      rem_reg [N];
    logic [QW-1:0]      q_reg [N];
    logic [QW-1:0]      nb_reg [N-1];
    logic [DW-1:0]      d_reg [N-1];

    // product split into two partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg <= feed * len_mot[31:0];
            phi_reg <= feed * len_mot[cxyft_pkg::SQ_ROOT_W-1:32];
            da_reg <= len_cart[DW-1:0];
            num_reg <= {{(NW-64){1'b0}}, plo_reg} + {phi_reg, 32'd0};
            db_reg <= da_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic [DW-1:0] rem_in, d_in;
            logic [QW-1:0] q_in, nb_in;
            logic [DW:0] cur, diff;
            logic fit;

            if (g == 0) begin : g_first
                assign rem_in = {1'b0, num_reg[NW-1:QW]};
                assign q_in = '0;
                assign nb_in = num_reg[QW-1:0];
                assign d_in = db_reg;
            end else begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign q_in = q_reg[g-1];
                assign nb_in = nb_reg[g-1];
                assign d_in = d_reg[g-1];
            end

            always_comb begin
                cur = {rem_in, nb_in[QW-1]};
                fit = cur >= {1'b0, d_in};
                diff = cur - {1'b0, d_in};
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[g] <= fit ? diff[DW-1:0] : cur[DW-1:0];
                    q_reg[g] <= {q_in[QW-2:0], fit};
                end
            end

            if (g < N - 1) begin : g_pass
                always_ff @(posedge aclk) begin
                    if (en) begin
                        nb_reg[g] <= {nb_in[QW-2:0], 1'b0};
                        d_reg[g] <= d_in;
                    end
                end
            end
        end
    endgenerate

    assign quot = q_reg[N-1];

endmodule

FILE: design/corexy_move_transform_feed_scale.sv
// corexy move transform with feed rescaling
//
// s_ channel: one linear move per transfer (target and start x/y/z in signed
// q16.16, feed in unsigned q16.16, rapid flag). m_ channel: one result per
// move: motor_a = k*x + y, motor_b = k*x - y (saturated), motor_z, scaled
// feed_out and zero_length.
// apb port: x_motor_factor at byte address 0 (k = 1 for 0/1, 2 for 2/3),
// written only while the block is idle; the user must keep to this, the
// block itself does not enforce it. throughput one move per cycle while
// no stall holds it. the path runs through front and multiply stages, the
// pipelined square root (one root bit per stage, 43 stages), the restoring
// feed divider (one quotient bit per stage, 35 stages) and the output stage.
// stall: the whole pipeline holds when a result waits and m_ready is low;
// s_ready then drops in the same cycle, nothing is lost or repeated.
// reset: all valid bits clear, x_motor_factor returns to 1.
module corexy_move_transform_feed_scale (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  cxyft_pkg::in_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output cxyft_pkg::out_t                   m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cxyft_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int LAT = cxyft_pkg::CORE_LAT;

    logic [1:0] factor_reg;
    logic k_two;
    logic en;

    // sideband delay line and valid bits, aligned with the datapath stages
    cxyft_pkg::side_t side_reg [LAT];
    logic [LAT-1:0] valid_reg;
    cxyft_pkg::side_t side_next;

    logic m_valid_reg;
    cxyft_pkg::out_t m_data_reg;

    logic [cxyft_pkg::SQ_RAD_W-1:0] cart_rad, mot_rad;
    logic [cxyft_pkg::SQ_ROOT_W-1:0] len_cart, len_mot;
    logic [cxyft_pkg::DV_Q_W-1:0] quot;

    logic signed [34:0] ta, tb, ktx, ty_ext;
    logic cfg_wr;

    // saturate a 35 bit signed sum to int32
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
            r = v[31:0];
        end else if (v[34]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7fff_ffff;
        end
        return r;
    endfunction

    // the whole pipeline advances unless a finished result is stuck
    assign en = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign k_two = factor_reg[1];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr == cxyft_pkg::REG_X_FACTOR_ADDR);
    assign prdata = (paddr == cxyft_pkg::REG_X_FACTOR_ADDR) ? {30'd0, factor_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= cxyft_pkg::X_FACTOR_RESET;
        end else if (cfg_wr) begin
            factor_reg <= pwdata[1:0];
        end
    end

    // motor mix of the target, computed on entry
    always_comb begin
        ktx = k_two ? {{2{s_data.target_x[31]}}, s_data.target_x, 1'b0}
                    : {{3{s_data.target_x[31]}}, s_data.target_x};
        ty_ext = {{3{s_data.target_y[31]}}, s_data.target_y};
        ta = ktx + ty_ext;
        tb = ktx - ty_ext;
        side_next.motor_a = sat32(ta);
        side_next.motor_b = sat32(tb);
        side_next.motor_z = s_data.target_z;
        side_next.feed_in = s_data.feed_in;
        side_next.zero_length = (s_data.target_x == s_data.start_x)
                                && (s_data.target_y == s_data.start_y)
                                && (s_data.target_z == s_data.start_z);
        side_next.bypass = s_data.rapid || side_next.zero_length;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < LAT; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= {valid_reg[LAT-2:0], s_valid};
            m_valid_reg <= valid_reg[LAT-1];
        end
    end

    // deltas, squares and sums
    cxyft_front u_front (
        .aclk     (aclk),
        .en       (en),
        .k_two    (k_two),
        .in_data  (s_data),
        .cart_rad (cart_rad),
        .mot_rad  (mot_rad)
    );

    // both move lengths in parallel
    cxyft_sqrt u_sqrt_cart (
        .aclk (aclk),
        .en   (en),
        .rad  (cart_rad),
        .root (len_cart)
    );

    cxyft_sqrt u_sqrt_mot (
        .aclk (aclk),
        .en   (en),
        .rad  (mot_rad),
        .root (len_mot)
    );

    // feed times motor length over cartesian length; feed is taken from
    // the sideband where the lengths come out of the square root
    cxyft_div u_div (
        .aclk     (aclk),
        .en       (en),
        .feed     (side_reg[cxyft_pkg::FRONT_LAT + cxyft_pkg::SQRT_LAT - 1].feed_in),
        .len_mot  (len_mot),
        .len_cart (len_cart),
        .quot     (quot)
    );

    // output register, feed saturation and bypass select
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.motor_a <= side_reg[LAT-1].motor_a;
            m_data_reg.motor_b <= side_reg[LAT-1].motor_b;
            m_data_reg.motor_z <= side_reg[LAT-1].motor_z;
            m_data_reg.zero_length <= side_reg[LAT-1].zero_length;
            if (side_reg[LAT-1].bypass) begin
                m_data_reg.feed_out <= side_reg[LAT-1].feed_in;
            end else if (quot[cxyft_pkg::DV_Q_W-1:32] != '0) begin
                m_data_reg.feed_out <= 32'hffff_ffff;
            end else begin
                m_data_reg.feed_out <= quot[31:0];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    // input side is held exactly when a result waits
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // a stalled pipeline keeps its valid bits
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    // a zero length move passes its feed unchanged and flags zero_length
    a_zero_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && valid_reg[LAT-1] && side_reg[LAT-1].zero_length)
        |=> (m_valid && m_data.zero_length && m_data.feed_out == $past(side_reg[LAT-1].feed_in)))
        else $error("zero length move feed not passed through");

    // register write lands
    a_cfg_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> factor_reg == $past(pwdata[1:0]))
        else $error("x factor write lost");

endmodule

FILE: tb/tb_corexy_move_transform_feed_scale.sv
module tb_corexy_move_transform_feed_scale;
    timeunit 1ns;
    timeprecision 1ps;

    // clock and reset
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    always #5 aclk = ~aclk;

    // move channel into the block
    logic s_valid = 1'b0;
    logic s_ready;
    cxyft_pkg::in_t  s_data = '0;

    // motor target channel out of the block
    logic m_valid;
    logic m_ready = 1'b0;
    cxyft_pkg::out_t m_data;

    // register port
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [cxyft_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                      pwdata = '0;
    logic [31:0]                      prdata;
    logic                             pready;

    corexy_move_transform_feed_scale dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor's copy of the x factor register
    logic [1:0] x_factor = cxyft_pkg::X_FACTOR_RESET;

    cxyft_pkg::out_t  motor_targets_due[$];   // expected results, oldest first
    int    moves_accepted = 0;
    int    results_checked = 0;
    int    errors = 0;
    int    zero_moves = 0;
    int    rapid_moves = 0;
    bit    quiet_period = 1'b0;    // no random idling on either side while set
    bit    hold_request = 1'b0;    // asks the receiver for a long hold-off
    localparam int HOLD_CYCLES = 400;

    // squared magnitude, exact
    function automatic logic [127:0] square_wide(longint v);
        logic [127:0] m;
        m = (v < 0) ? 128'(-v) : 128'(v);
        return m * m;
    endfunction

    // floor square root, one result bit per pass
    function automatic logic [127:0] floor_sqrt(logic [127:0] n);
        logic [127:0] root;
        logic [127:0] b;
        logic [127:0] t;
        root = '0;
        b = 128'd1 << 126;
        while (b != 0) begin
            t = root + b;
            if (n >= t) begin
                n = n - t;
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] clamp_s32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // motor mix and feed rescale for one move
    function automatic cxyft_pkg::out_t predict_motor_move(cxyft_pkg::in_t mv,
                                                           logic [1:0] fac);
        longint k, tx, ty, tz, sx, sy, sz, ta, tb, sa, sb;
        logic [127:0] cart, mot, lc, lm, q;
        cxyft_pkg::out_t r;
        k  = (fac <= 2'd1) ? 1 : 2;
        tx = mv.target_x; ty = mv.target_y; tz = mv.target_z;
        sx = mv.start_x;  sy = mv.start_y;  sz = mv.start_z;
        ta = k * tx + ty; tb = k * tx - ty;
        sa = k * sx + sy; sb = k * sx - sy;
        cart = square_wide(tx - sx) + square_wide(ty - sy) + square_wide(tz - sz);
        mot  = square_wide(ta - sa) + square_wide(tb - sb) + square_wide(tz - sz);
        r.motor_a = clamp_s32(ta);
        r.motor_b = clamp_s32(tb);
        r.motor_z = mv.target_z;
        r.zero_length = (cart == 0);
        r.feed_out = mv.feed_in;
        if (!mv.rapid && cart != 0) begin
            lc = floor_sqrt(cart << cxyft_pkg::LEN_EXTRA_SHIFT);
            lm = floor_sqrt(mot << cxyft_pkg::LEN_EXTRA_SHIFT);
            q = (128'(mv.feed_in) * lm) / lc;
            r.feed_out = (q > 128'hffff_ffff) ? 32'hffff_ffff : q[31:0];
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_period || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // input transfer monitor: predicts at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            motor_targets_due.push_back(predict_motor_move(s_data, x_factor));
            moves_accepted <= moves_accepted + 1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        cxyft_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (motor_targets_due.size() == 0) begin
                $display("%0t: unexpected result, got %p", $time, m_data);
                errors++;
            end else begin
                want = motor_targets_due.pop_front();
                results_checked++;
                if (m_data.motor_a !== want.motor_a) begin
                    $display("%0t: motor_a expected %h got %h", $time,
                             want.motor_a, m_data.motor_a);
                    errors++;
                end
                if (m_data.motor_b !== want.motor_b) begin
                    $display("%0t: motor_b expected %h got %h", $time,
                             want.motor_b, m_data.motor_b);
                    errors++;
                end
                if (m_data.motor_z !== want.motor_z) begin
                    $display("%0t: motor_z expected %h got %h", $time,
                             want.motor_z, m_data.motor_z);
                    errors++;
                end
                if (m_data.feed_out !== want.feed_out) begin
                    $display("%0t: feed_out expected %h got %h", $time,
                             want.feed_out, m_data.feed_out);
                    errors++;
                end
                if (m_data.zero_length !== want.zero_length) begin
                    $display("%0t: zero_length expected %b got %b", $time,
                             want.zero_length, m_data.zero_length);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off counted here on request
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
                hold_request = 1'b0;
            end
            n = idle_len();
            if (n == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // offer one move, return once it has been transferred
    task automatic send_move(cxyft_pkg::in_t mv);
        int gap;
        int target;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        if (mv.rapid) rapid_moves++;
        target = moves_accepted + 1;
        s_valid <= 1'b1;
        s_data  <= mv;
        wait (moves_accepted == target);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        wait (motor_targets_due.size() == 0);
        repeat (cxyft_pkg::CORE_LAT + 20) @(negedge aclk);
    endtask

    // register write, then read back; only while idle
    task automatic write_x_factor(logic [1:0] val);
        s_valid <= 1'b0;
        drain_results();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= cxyft_pkg::REG_X_FACTOR_ADDR;
        pwdata <= {30'($urandom), val};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        x_factor = val;
        @(negedge aclk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[1:0] !== val) begin
            $display("%0t: x_motor_factor readback expected %h got %h", $time,
                     val, prdata[1:0]);
            errors++;
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic cxyft_pkg::in_t make_move(int sx, int sy, int sz,
                                                 int tx, int ty, int tz,
                                                 logic [31:0] feed, bit rapid);
        cxyft_pkg::in_t mv;
        mv.start_x = sx; mv.start_y = sy; mv.start_z = sz;
        mv.target_x = tx; mv.target_y = ty; mv.target_z = tz;
        mv.feed_in = feed; mv.rapid = rapid;
        return mv;
    endfunction

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
        endcase
    endfunction

    // well-formed move: start near target with random deltas, start equal to target, or noise
    function automatic cxyft_pkg::in_t random_move();
        cxyft_pkg::in_t mv;
        int r;
        r = $urandom_range(0, 99);
        mv.target_x = rand_pos(); mv.target_y = rand_pos(); mv.target_z = rand_pos();
        mv.feed_in = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0fff_ffff);
        mv.rapid = ($urandom_range(0, 4) == 0);
        if (r < 20) begin
            mv.start_x = rand_pos(); mv.start_y = rand_pos(); mv.start_z = rand_pos();
        end else if (r < 28) begin
            mv.start_x = mv.target_x; mv.start_y = mv.target_y; mv.start_z = mv.target_z;
        end else begin
            mv.start_x = mv.target_x - ($urandom_range(0, 1) ? $urandom_range(0, 32'h000f_ffff)
                                                               : $urandom_range(0, 15));
            mv.start_y = mv.target_y + ($urandom_range(0, 2) ? $urandom_range(0, 32'h000f_ffff) : 0);
            mv.start_z = mv.target_z - ($urandom_range(0, 2) ? 0 : $urandom_range(0, 32'h0000_ffff));
        end
        return mv;
    endfunction

    // extremes, zero-length and rapid cases, pure single-axis moves
    task automatic test_directed_moves();
        send_move(make_move(0, 0, 0, 0, 0, 0, 32'h0001_0000, 1'b0));
        send_move(make_move(5, 6, 7, 5, 6, 7, 32'hffff_ffff, 1'b1));
        send_move(make_move(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0010_0000, 1'b0));
        send_move(make_move(0, 0, 0, 0, 32'h0001_0000, 0, 32'h0010_0000, 1'b0));
        send_move(make_move(0, 0, 0, 0, 0, 32'h0001_0000, 32'h0010_0000, 1'b0));
        send_move(make_move(0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 32'h0010_0000, 1'b1));
        send_move(make_move(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b0));
        send_move(make_move(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1'b0));
        send_move(make_move(32'h7fff_ffff, 32'h8000_0000, 0,
                            32'h8000_0000, 32'h7fff_ffff, 0, 32'h0, 1'b0));
        send_move(make_move(0, 0, 0, 1, 0, 0, 32'hffff_ffff, 1'b0));
        send_move(make_move(-1, -1, -1, 32'h7fff_ffff, 32'h8000_0000, -1, 32'h8000_0001, 1'b0));
        send_move(make_move(0, 0, 0, 0, 0, 32'h8000_0000, 32'h1234_5678, 1'b0));
    endtask

    task automatic test_random_moves(int count);
        int n;
        cxyft_pkg::in_t mv;
        for (n = 0; n < count; n++) begin
            mv = random_move();
            if (mv.target_x == mv.start_x && mv.target_y == mv.start_y &&
                mv.target_z == mv.start_z)
                zero_moves++;
            send_move(mv);
        end
    endtask

    // receiver holds off while the sender keeps offering, so the pipe backs up
    task automatic test_backpressure();
        hold_request = 1'b1;
        quiet_period = 1'b1;
        test_random_moves(150);
        quiet_period = 1'b0;
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_moves();
        write_x_factor(2'd2);
        test_directed_moves();
        write_x_factor(2'd0);
        test_random_moves(180);
        write_x_factor(2'd3);
        test_random_moves(180);
        test_backpressure();
        write_x_factor(2'd1);
        quiet_period = 1'b1;
        test_random_moves(120);
        quiet_period = 1'b0;
        test_random_moves(120);
        write_x_factor(2'd2);
        test_random_moves(330);

        s_valid <= 1'b0;
        drain_results();
        $display("covered %0d moves (%0d rapid, %0d zero-length) over x factors 0..3,",
                 moves_accepted, rapid_moves, zero_moves);
        $display("%0d results checked, incl. a %0d-cycle receiver hold-off",
                 results_checked, HOLD_CYCLES);
        if (errors == 0) begin
            $display("PASS corexy_move_transform_feed_scale");
        end else begin
            $display("FAIL corexy_move_transform_feed_scale");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("FAIL corexy_move_transform_feed_scale");
        $finish;
    end

endmodule
